[rtl/printf_conversion_spec_parser_defines.svh]
// ----------------------------------------------------------------------------
// printf conversion spec parser: assertion macros
// Concurrent assertion wrappers used by the parser; they compile to nothing
// when SYNTHESIS is defined. They sample on clk and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRINTF_CONVERSION_SPEC_PARSER_DEFINES_SVH
`define PRINTF_CONVERSION_SPEC_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PCSP_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
// Next-cycle implication.
`define PCSP_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define PCSP_ASSERT_IMPL(label, pre, post, msg)
`define PCSP_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

[rtl/pcsp_pkg.sv]
// ----------------------------------------------------------------------------
// pcsp_pkg
// Types, character codes, type masks and helper functions for the printf
// conversion specifier parser.
// ----------------------------------------------------------------------------
package pcsp_pkg;

	// Sizes of the decimal accumulators and the digit counter.
	localparam int MAX_DIGITS = 20;
	localparam int VALUE_BITS = 32;
	localparam int DCNT_BITS  = $clog2(MAX_DIGITS + 1);

	// Parser phases.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FLAGS,
		PH_WIDTH,
		PH_PREC,
		PH_DOT,
		PH_PDIG,
		PH_LEN,
		PH_TYPE
	} phase_t;

	// Conversion type codes as they appear on the result.
	typedef enum logic [3:0] {
		CT_PERCENT, CT_D, CT_I, CT_O, CT_U, CT_LX, CT_UX, CT_LE,
		CT_UE, CT_F, CT_LG, CT_UG, CT_C, CT_S, CT_P, CT_N
	} conv_t;

	// Length modifier codes.
	typedef enum logic [1:0] {
		LM_NONE,
		LM_SHORT,
		LM_LONG,
		LM_LDOUBLE
	} len_t;

	// Flag bit positions.
	localparam int FB_ALT   = 0;
	localparam int FB_ZERO  = 1;
	localparam int FB_LEFT  = 2;
	localparam int FB_PLUS  = 3;
	localparam int FB_SPACE = 4;

	// Characters of the grammar.
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_LOW_H   = 8'h68;
	localparam logic [7:0] CH_LOW_L   = 8'h6C;
	localparam logic [7:0] CH_UP_L    = 8'h4C;

	// Types that accept each flag, length or precision, one bit per type code.
	localparam logic [15:0] MASK_ALT   = 16'h0FE0;
	localparam logic [15:0] MASK_ZPAD  = 16'h0FFE;
	localparam logic [15:0] MASK_HL    = 16'h807E;
	localparam logic [15:0] MASK_LDBL  = 16'h0F80;
	localparam logic [15:0] MASK_PREC  = 16'h2FFE;

	// Specifier marks collected while parsing.
	typedef struct packed {
		len_t lm;
		logic pa;
		logic pg;
		logic wa;
		logic wg;
	} marks_t;

	// One result item.
	typedef struct packed {
		logic                  status;
		conv_t                 conv_type;
		logic [4:0]            flag_bits;
		logic                  width_given;
		logic                  width_from_arg;
		logic [VALUE_BITS-1:0] width_value;
		logic                  prec_given;
		logic                  prec_from_arg;
		logic [VALUE_BITS-1:0] prec_value;
		len_t                  len_code;
		logic [7:0]            chars_used;
	} res_t;

	// Type letter lookup: bit 4 is set when the letter is a known type.
	function automatic logic [4:0] type_lookup(input logic [7:0] c);
		logic [4:0] r;
		unique case (c)
			8'h64:   r = {1'b1, CT_D};
			8'h69:   r = {1'b1, CT_I};
			8'h6F:   r = {1'b1, CT_O};
			8'h75:   r = {1'b1, CT_U};
			8'h78:   r = {1'b1, CT_LX};
			8'h58:   r = {1'b1, CT_UX};
			8'h65:   r = {1'b1, CT_LE};
			8'h45:   r = {1'b1, CT_UE};
			8'h66:   r = {1'b1, CT_F};
			8'h67:   r = {1'b1, CT_LG};
			8'h47:   r = {1'b1, CT_UG};
			8'h63:   r = {1'b1, CT_C};
			8'h73:   r = {1'b1, CT_S};
			8'h70:   r = {1'b1, CT_P};
			8'h6E:   r = {1'b1, CT_N};
			default: r = {1'b0, CT_PERCENT};
		endcase
		return r;
	endfunction

	// Decimal accumulate acc*10 + d, saturating at all ones.
	function automatic logic [VALUE_BITS-1:0] acc_step(input logic [VALUE_BITS-1:0] acc,
			input logic [3:0] d);
		logic [VALUE_BITS+3:0] ext;
		logic [VALUE_BITS+3:0] sum;
		ext = {4'b0, acc};
		sum = (ext << 3) + (ext << 1) + {{VALUE_BITS{1'b0}}, d};
		if (sum[VALUE_BITS+3:VALUE_BITS] != 4'b0)
			return {VALUE_BITS{1'b1}};
		return sum[VALUE_BITS-1:0];
	endfunction

	// Saturating character count increment.
	function automatic logic [7:0] char_inc(input logic [7:0] n);
		return (n == 8'hFF) ? n : n + 8'd1;
	endfunction

endpackage

[rtl/printf_conversion_spec_parser.sv]
// ----------------------------------------------------------------------------
// printf_conversion_spec_parser
// Parses one printf conversion specifier from a stream of characters.
// The input channel (in_valid, in_stall, ch) takes one character per item;
// a NUL ends the string. The output channel (out_valid, out_stall and the
// result fields) gives one item when a specifier completes or fails, and
// nothing for characters that only extend it.
// A character is registered on acceptance and decoded against the parser
// state from the input register; its result item is registered in the
// result register. One character is taken per cycle while the output
// moves; the decimal accumulate and the type decode both fit in that cycle.
// While out_stall holds a pending result, the decode stage waits and
// in_stall rises once a character is waiting in the input register.
// Reset empties both registers and returns the parser to waiting for '%'.
// ----------------------------------------------------------------------------
`include "printf_conversion_spec_parser_defines.svh"

module printf_conversion_spec_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      ch,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            status,
	output logic [3:0]                      conv_type,
	output logic [4:0]                      flag_bits,
	output logic                            width_given,
	output logic                            width_from_arg,
	output logic [pcsp_pkg::VALUE_BITS-1:0] width_value,
	output logic                            prec_given,
	output logic                            prec_from_arg,
	output logic [pcsp_pkg::VALUE_BITS-1:0] prec_value,
	output logic [1:0]                      len_code,
	output logic [7:0]                      chars_used
);
	import pcsp_pkg::*;

	// Pipeline registers.
	logic       v_s1;
	logic [7:0] ch_s1;
	logic       v_s2;
	res_t       res_s2;

	// Parser state.
	phase_t                phase_q;
	logic [4:0]            flags_q;
	logic [VALUE_BITS-1:0] wacc_q;
	logic [VALUE_BITS-1:0] pacc_q;
	marks_t                marks_q;
	logic [DCNT_BITS-1:0]  dcnt_q;
	logic [7:0]            ccnt_q;

	// Next state and result of the decode stage.
	phase_t                phase_n;
	logic [4:0]            flags_n;
	logic [VALUE_BITS-1:0] wacc_n;
	logic [VALUE_BITS-1:0] pacc_n;
	marks_t                marks_n;
	logic [DCNT_BITS-1:0]  dcnt_n;
	logic [7:0]            ccnt_n;
	res_t                  res_w;
	logic                  has_res;

	logic       adv;
	logic       in_acc;
	logic       done;
	logic       emit_err;
	logic       emit_pct;
	logic       emit_spec;
	logic       spec_bad;
	logic [7:0] err_cnt;
	logic [7:0] cc;
	logic       dig;
	logic       at_max;
	logic [4:0] tl;
	logic [15:0] tb;

	// Handshake: the decode stage moves whenever the output register is free.
	assign adv      = !v_s2 || !out_stall;
	assign in_stall = v_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	// Character decode against the parser state.
	always_comb begin
		phase_n   = phase_q;
		flags_n   = flags_q;
		wacc_n    = wacc_q;
		pacc_n    = pacc_q;
		marks_n   = marks_q;
		dcnt_n    = dcnt_q;
		ccnt_n    = ccnt_q;
		cc        = char_inc(ccnt_q);
		dig       = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
		at_max    = (dcnt_q >= DCNT_BITS'(MAX_DIGITS));
		tl        = type_lookup(ch_s1);
		tb        = 16'b1 << tl[3:0];
		done      = 1'b0;
		emit_err  = 1'b0;
		emit_pct  = 1'b0;
		emit_spec = 1'b0;
		err_cnt   = cc;

		// Waiting for '%', or a terminator inside a specifier.
		if (phase_q == PH_IDLE) begin
			done = 1'b1;
			if (ch_s1 == CH_PERCENT) begin
				ccnt_n  = 8'd1;
				phase_n = PH_FLAGS;
			end else begin
				emit_err = 1'b1;
				err_cnt  = (ch_s1 != CH_NUL) ? 8'd1 : 8'd0;
			end
		end else if (ch_s1 == CH_NUL) begin
			done     = 1'b1;
			emit_err = 1'b1;
			err_cnt  = ccnt_q;
		end else begin
			ccnt_n = cc;
		end

		// Flags, and the percent literal right after the '%'.
		if (!done && phase_q == PH_FLAGS) begin
			done = 1'b1;
			if (cc == 8'd2 && ch_s1 == CH_PERCENT)
				emit_pct = 1'b1;
			else if (ch_s1 == CH_HASH)
				flags_n[FB_ALT] = 1'b1;
			else if (ch_s1 == CH_ZERO)
				flags_n[FB_ZERO] = 1'b1;
			else if (ch_s1 == CH_MINUS)
				flags_n[FB_LEFT] = 1'b1;
			else if (ch_s1 == CH_PLUS)
				flags_n[FB_PLUS] = 1'b1;
			else if (ch_s1 == CH_SPACE)
				flags_n[FB_SPACE] = 1'b1;
			else
				done = 1'b0;
		end

		// Field width: '*' or decimal digits.
		if (!done && (phase_q == PH_FLAGS || phase_q == PH_WIDTH)) begin
			done = 1'b1;
			if (dcnt_q == '0 && ch_s1 == CH_STAR) begin
				marks_n.wg = 1'b1;
				marks_n.wa = 1'b1;
				phase_n    = PH_PREC;
			end else if (at_max) begin
				emit_err = 1'b1;
			end else if (dig) begin
				marks_n.wg = 1'b1;
				wacc_n     = acc_step(wacc_q, ch_s1[3:0]);
				dcnt_n     = dcnt_q + 1'b1;
				phase_n    = PH_WIDTH;
			end else begin
				done = 1'b0;
			end
		end

		// Dot that opens the precision.
		if (!done && (phase_q == PH_FLAGS || phase_q == PH_WIDTH || phase_q == PH_PREC)) begin
			if (ch_s1 == CH_DOT) begin
				done    = 1'b1;
				dcnt_n  = '0;
				phase_n = PH_DOT;
			end
		end

		// First character after the dot: the precision is given from here on.
		if (!done && phase_q == PH_DOT) begin
			marks_n.pg = 1'b1;
			if (ch_s1 == CH_STAR) begin
				done       = 1'b1;
				marks_n.pa = 1'b1;
				phase_n    = PH_LEN;
			end
		end

		// Precision digits.
		if (!done && (phase_q == PH_DOT || phase_q == PH_PDIG)) begin
			done = 1'b1;
			if (at_max) begin
				emit_err = 1'b1;
			end else if (dig) begin
				pacc_n  = acc_step(pacc_q, ch_s1[3:0]);
				dcnt_n  = dcnt_q + 1'b1;
				phase_n = PH_PDIG;
			end else begin
				done = 1'b0;
			end
		end

		// Length modifier.
		if (!done && phase_q != PH_TYPE) begin
			done = 1'b1;
			if (ch_s1 == CH_LOW_H) begin
				marks_n.lm = LM_SHORT;
				phase_n    = PH_TYPE;
			end else if (ch_s1 == CH_LOW_L) begin
				marks_n.lm = LM_LONG;
				phase_n    = PH_TYPE;
			end else if (ch_s1 == CH_UP_L) begin
				marks_n.lm = LM_LDOUBLE;
				phase_n    = PH_TYPE;
			end else begin
				done = 1'b0;
			end
		end

		// Type letter ends the specifier.
		if (!done) begin
			if (tl[4])
				emit_spec = 1'b1;
			else
				emit_err = 1'b1;
		end

		// Check the flags, length and precision against the type.
		spec_bad = (flags_n[FB_ALT] && (tb & MASK_ALT) == '0)
			|| (flags_n[FB_ZERO] && (tb & MASK_ZPAD) == '0)
			|| ((marks_n.lm == LM_SHORT || marks_n.lm == LM_LONG) && (tb & MASK_HL) == '0)
			|| (marks_n.lm == LM_LDOUBLE && (tb & MASK_LDBL) == '0)
			|| (marks_n.pg && (tb & MASK_PREC) == '0);

		// Build the result item.
		res_w           = '0;
		res_w.conv_type = CT_PERCENT;
		res_w.len_code  = LM_NONE;
		if (emit_err || (emit_spec && spec_bad)) begin
			res_w.status     = 1'b1;
			res_w.chars_used = err_cnt;
		end else if (emit_pct) begin
			res_w.chars_used = cc;
		end else if (emit_spec) begin
			res_w.conv_type      = conv_t'(tl[3:0]);
			res_w.flag_bits      = flags_n;
			res_w.width_given    = marks_n.wg;
			res_w.width_from_arg = marks_n.wa;
			res_w.width_value    = wacc_n;
			res_w.prec_given     = marks_n.pg;
			res_w.prec_from_arg  = marks_n.pa;
			res_w.prec_value     = pacc_n;
			res_w.len_code       = marks_n.lm;
			res_w.chars_used     = cc;
		end
		has_res = emit_err || emit_pct || emit_spec;

		// Every result returns the parser to its idle state.
		if (has_res) begin
			phase_n = PH_IDLE;
			flags_n = '0;
			wacc_n  = '0;
			pacc_n  = '0;
			marks_n = '0;
			dcnt_n  = '0;
			ccnt_n  = '0;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_s1 <= ch;
		end
	end

	// Parser state update when a character is decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			flags_q <= '0;
			wacc_q  <= '0;
			pacc_q  <= '0;
			marks_q <= '0;
			dcnt_q  <= '0;
			ccnt_q  <= '0;
		end else if (v_s1 && adv) begin
			phase_q <= phase_n;
			flags_q <= flags_n;
			wacc_q  <= wacc_n;
			pacc_q  <= pacc_n;
			marks_q <= marks_n;
			dcnt_q  <= dcnt_n;
			ccnt_q  <= ccnt_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_w;
		end
	end

	// Output ports.
	assign out_valid      = v_s2;
	assign status         = res_s2.status;
	assign conv_type      = res_s2.conv_type;
	assign flag_bits      = res_s2.flag_bits;
	assign width_given    = res_s2.width_given;
	assign width_from_arg = res_s2.width_from_arg;
	assign width_value    = res_s2.width_value;
	assign prec_given     = res_s2.prec_given;
	assign prec_from_arg  = res_s2.prec_from_arg;
	assign prec_value     = res_s2.prec_value;
	assign len_code       = res_s2.len_code;
	assign chars_used     = res_s2.chars_used;

	// Checks on the parser.
	`PCSP_ASSERT_IMPL(a_err_clean, v_s2 && res_s2.status,
		res_s2.conv_type == CT_PERCENT && res_s2.flag_bits == '0
		&& res_s2.width_value == '0 && res_s2.prec_value == '0
		&& res_s2.len_code == LM_NONE, "error item carries a non-zero field")
	`PCSP_ASSERT_NEXT(a_idle_after_res, v_s1 && adv && has_res,
		phase_q == PH_IDLE && ccnt_q == '0, "parser not idle after a result")
	`PCSP_ASSERT_IMPL(a_arg_implies_given, v_s2,
		(!res_s2.width_from_arg || res_s2.width_given)
		&& (!res_s2.prec_from_arg || res_s2.prec_given),
		"argument mark without given mark")
	`PCSP_ASSERT_IMPL(a_dcnt_range, 1'b1, dcnt_q <= DCNT_BITS'(MAX_DIGITS), "digit count beyond its limit")

endmodule

[verif/spec_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spec_checker
// Watches both channels of the printf conversion specifier parser. Each
// character accepted on the input runs through a local model of the parser;
// any result it predicts is queued. Each result accepted on the output is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module spec_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [7:0]                      ch,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            status,
	input  logic [3:0]                      conv_type,
	input  logic [4:0]                      flag_bits,
	input  logic                            width_given,
	input  logic                            width_from_arg,
	input  logic [pcsp_pkg::VALUE_BITS-1:0] width_value,
	input  logic                            prec_given,
	input  logic                            prec_from_arg,
	input  logic [pcsp_pkg::VALUE_BITS-1:0] prec_value,
	input  logic [1:0]                      len_code,
	input  logic [7:0]                      chars_used,
	output int                              fail_count,
	output int                              pending,
	output int                              results_seen,
	output int                              valid_seen
);
	import pcsp_pkg::*;

	// Model state of the parser.
	phase_t                spec_phase;
	logic [4:0]            spec_flags;
	logic [VALUE_BITS-1:0] spec_wacc;
	logic [VALUE_BITS-1:0] spec_pacc;
	marks_t                spec_marks;
	logic [4:0]            spec_digits;
	logic [7:0]            spec_chars;

	// Results predicted but not yet seen on the output.
	res_t pending_specs[$];
	res_t next_item;

	int n_fail    = 0;
	int n_results = 0;
	int n_valid   = 0;

	function automatic void clear_parse();
		spec_phase  = PH_IDLE;
		spec_flags  = '0;
		spec_wacc   = '0;
		spec_pacc   = '0;
		spec_marks  = '0;
		spec_digits = '0;
		spec_chars  = '0;
	endfunction

	// Decimal accumulate that sticks at the largest value.
	function automatic logic [VALUE_BITS-1:0] dec_push(input logic [VALUE_BITS-1:0] acc,
			input int unsigned d);
		longint unsigned top_val;
		longint unsigned a;
		logic [VALUE_BITS-1:0] r;
		top_val = (64'd1 << VALUE_BITS) - 64'd1;
		a = acc;
		if (a > (top_val - d) / 10)
			r = top_val[VALUE_BITS-1:0];
		else
			r = VALUE_BITS'(a * 10 + d);
		return r;
	endfunction

	function automatic bit letter_to_conv(input logic [7:0] c, output conv_t t);
		t = CT_PERCENT;
		case (c)
			"d": t = CT_D;
			"i": t = CT_I;
			"o": t = CT_O;
			"u": t = CT_U;
			"x": t = CT_LX;
			"X": t = CT_UX;
			"e": t = CT_LE;
			"E": t = CT_UE;
			"f": t = CT_F;
			"g": t = CT_LG;
			"G": t = CT_UG;
			"c": t = CT_C;
			"s": t = CT_S;
			"p": t = CT_P;
			"n": t = CT_N;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// Error result: only status and the character count survive.
	function automatic res_t fail_item(input logic [7:0] count);
		res_t r;
		r = '0;
		r.status = 1'b1;
		r.chars_used = count;
		clear_parse();
		return r;
	endfunction

	// A type letter closes the specifier; check the combination against it.
	function automatic res_t spec_item(input conv_t t);
		res_t r;
		logic [15:0] tb;
		bit ok;
		tb = 16'd1 << t;
		ok = 1'b1;
		if (spec_flags[FB_ALT] && (tb & MASK_ALT) == 16'd0)
			ok = 1'b0;
		if (spec_flags[FB_ZERO] && (tb & MASK_ZPAD) == 16'd0)
			ok = 1'b0;
		if ((spec_marks.lm == LM_SHORT || spec_marks.lm == LM_LONG) && (tb & MASK_HL) == 16'd0)
			ok = 1'b0;
		if (spec_marks.lm == LM_LDOUBLE && (tb & MASK_LDBL) == 16'd0)
			ok = 1'b0;
		if (spec_marks.pg && (tb & MASK_PREC) == 16'd0)
			ok = 1'b0;
		if (!ok)
			return fail_item(spec_chars);
		r = '0;
		r.conv_type      = t;
		r.flag_bits      = spec_flags;
		r.width_given    = spec_marks.wg;
		r.width_from_arg = spec_marks.wa;
		r.width_value    = spec_wacc;
		r.prec_given     = spec_marks.pg;
		r.prec_from_arg  = spec_marks.pa;
		r.prec_value     = spec_pacc;
		r.len_code       = spec_marks.lm;
		r.chars_used     = spec_chars;
		clear_parse();
		return r;
	endfunction

	// One character through the model; returns 1 when it produces a result item.
	// Each stage hands the character on to the next one when it does not use it.
	function automatic bit parse_char(input logic [7:0] c, output res_t r);
		phase_t st;
		bit dig;
		conv_t t;
		r = '0;
		dig = (c >= CH_ZERO && c <= CH_NINE);
		if (spec_phase == PH_IDLE) begin
			if (c == CH_PERCENT) begin
				spec_chars = 8'd1;
				spec_phase = PH_FLAGS;
				return 1'b0;
			end
			r = fail_item((c != CH_NUL) ? 8'd1 : 8'd0);
			return 1'b1;
		end
		if (c == CH_NUL) begin
			r = fail_item(spec_chars);
			return 1'b1;
		end
		if (spec_chars != 8'hFF)
			spec_chars++;
		st = spec_phase;

		// Flags, and the percent literal straight after the opening percent.
		if (st == PH_FLAGS) begin
			if (spec_chars == 8'd2 && c == CH_PERCENT) begin
				r.chars_used = 8'd2;
				clear_parse();
				return 1'b1;
			end
			case (c)
				CH_HASH:  begin spec_flags[FB_ALT] = 1'b1; return 1'b0; end
				CH_ZERO:  begin spec_flags[FB_ZERO] = 1'b1; return 1'b0; end
				CH_MINUS: begin spec_flags[FB_LEFT] = 1'b1; return 1'b0; end
				CH_PLUS:  begin spec_flags[FB_PLUS] = 1'b1; return 1'b0; end
				CH_SPACE: begin spec_flags[FB_SPACE] = 1'b1; return 1'b0; end
				default:  st = PH_WIDTH;
			endcase
		end

		// Width: a star or a run of digits.
		if (st == PH_WIDTH) begin
			if (spec_digits == 0 && c == CH_STAR) begin
				spec_marks.wg = 1'b1;
				spec_marks.wa = 1'b1;
				spec_phase = PH_PREC;
				return 1'b0;
			end
			if (spec_digits >= MAX_DIGITS) begin
				r = fail_item(spec_chars);
				return 1'b1;
			end
			if (dig) begin
				spec_marks.wg = 1'b1;
				spec_wacc = dec_push(spec_wacc, c - CH_ZERO);
				spec_digits++;
				spec_phase = PH_WIDTH;
				return 1'b0;
			end
			st = PH_PREC;
		end

		// The dot that opens a precision; anything else goes to the length.
		if (st == PH_PREC) begin
			if (c == CH_DOT) begin
				spec_digits = '0;
				spec_phase = PH_DOT;
				return 1'b0;
			end
			st = PH_LEN;
		end

		if (st == PH_DOT) begin
			spec_marks.pg = 1'b1;
			if (c == CH_STAR) begin
				spec_marks.pa = 1'b1;
				spec_phase = PH_LEN;
				return 1'b0;
			end
			st = PH_PDIG;
		end

		if (st == PH_PDIG) begin
			if (spec_digits >= MAX_DIGITS) begin
				r = fail_item(spec_chars);
				return 1'b1;
			end
			if (dig) begin
				spec_pacc = dec_push(spec_pacc, c - CH_ZERO);
				spec_digits++;
				spec_phase = PH_PDIG;
				return 1'b0;
			end
			st = PH_LEN;
		end

		// A single length modifier.
		if (st == PH_LEN) begin
			if (c == CH_LOW_H || c == CH_LOW_L || c == CH_UP_L) begin
				spec_marks.lm = (c == CH_LOW_H) ? LM_SHORT :
						(c == CH_LOW_L) ? LM_LONG : LM_LDOUBLE;
				spec_phase = PH_TYPE;
				return 1'b0;
			end
			st = PH_TYPE;
		end

		// Whatever is left must be a type letter.
		if (!letter_to_conv(c, t)) begin
			r = fail_item(spec_chars);
			return 1'b1;
		end
		r = spec_item(t);
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (n_fail < 50)
			$display("MISMATCH at result %0d: %s got %0h, expected %0h",
				n_results, what, got, want);
		n_fail++;
	endtask

	task automatic check_result();
		res_t want;
		if (pending_specs.size() == 0) begin
			report_mismatch("result with nothing pending, chars_used", chars_used, 0);
			return;
		end
		want = pending_specs.pop_front();
		if (status !== want.status)
			report_mismatch("status", status, want.status);
		if (conv_type !== want.conv_type)
			report_mismatch("conv_type", conv_type, want.conv_type);
		if (flag_bits !== want.flag_bits)
			report_mismatch("flag_bits", flag_bits, want.flag_bits);
		if (width_given !== want.width_given)
			report_mismatch("width_given", width_given, want.width_given);
		if (width_from_arg !== want.width_from_arg)
			report_mismatch("width_from_arg", width_from_arg, want.width_from_arg);
		if (width_value !== want.width_value)
			report_mismatch("width_value", width_value, want.width_value);
		if (prec_given !== want.prec_given)
			report_mismatch("prec_given", prec_given, want.prec_given);
		if (prec_from_arg !== want.prec_from_arg)
			report_mismatch("prec_from_arg", prec_from_arg, want.prec_from_arg);
		if (prec_value !== want.prec_value)
			report_mismatch("prec_value", prec_value, want.prec_value);
		if (len_code !== want.len_code)
			report_mismatch("len_code", len_code, want.len_code);
		if (chars_used !== want.chars_used)
			report_mismatch("chars_used", chars_used, want.chars_used);
		if (want.status == 1'b0)
			n_valid++;
		n_results++;
	endtask

	// Results are checked before the character of the same edge is modelled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			pending_specs.delete();
			fail_count   <= 0;
			pending      <= 0;
			results_seen <= 0;
			valid_seen   <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall) begin
				if (parse_char(ch, next_item))
					pending_specs.push_back(next_item);
			end
			fail_count   <= n_fail;
			pending      <= pending_specs.size();
			results_seen <= n_results;
			valid_seen   <= n_valid;
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives format-string characters into the printf conversion specifier
// parser: a few hand-picked specifiers first, then random specifiers that
// are mostly well formed, mixed with stray bytes and cut-off specifiers.
// Three idling rounds, a long output hold-off and drain pauses are applied;
// the checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
	import pcsp_pkg::*;

	localparam int ITEMS       = 1650;
	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 200000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] ch        = 8'h00;
	logic       out_stall = 1'b0;

	logic                  in_stall;
	logic                  out_valid;
	logic                  status;
	logic [3:0]            conv_type;
	logic [4:0]            flag_bits;
	logic                  width_given;
	logic                  width_from_arg;
	logic [VALUE_BITS-1:0] width_value;
	logic                  prec_given;
	logic                  prec_from_arg;
	logic [VALUE_BITS-1:0] prec_value;
	logic [1:0]            len_code;
	logic [7:0]            chars_used;

	int fail_count;
	int pending;
	int results_seen;
	int valid_seen;

	int send_idle_pct = 34;
	int recv_idle_pct = 74;
	bit hold_req      = 1'b0;
	int chars_sent    = 0;
	int specs_sent    = 0;
	int cycle_count   = 0;

	logic [7:0] spec_text[$];

	printf_conversion_spec_parser u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.ch             (ch),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.conv_type      (conv_type),
		.flag_bits      (flag_bits),
		.width_given    (width_given),
		.width_from_arg (width_from_arg),
		.width_value    (width_value),
		.prec_given     (prec_given),
		.prec_from_arg  (prec_from_arg),
		.prec_value     (prec_value),
		.len_code       (len_code),
		.chars_used     (chars_used)
	);

	spec_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.ch             (ch),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.conv_type      (conv_type),
		.flag_bits      (flag_bits),
		.width_given    (width_given),
		.width_from_arg (width_from_arg),
		.width_value    (width_value),
		.prec_given     (prec_given),
		.prec_from_arg  (prec_from_arg),
		.prec_value     (prec_value),
		.len_code       (len_code),
		.chars_used     (chars_used),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_seen   (results_seen),
		.valid_seen     (valid_seen)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending", cycle_count, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin : receiver
		int held;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				held++;
				if (held >= HOLD_CYCLES) begin
					hold_req = 1'b0;
					held = 0;
				end
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// Offer one character and hold it until the parser takes the item.
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string txt);
		int i;
		for (i = 0; i < txt.len(); i++)
			send_char(txt[i]);
	endtask

	// Stop offering and wait until every predicted result has been taken.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] conv_letter(input conv_t t);
		case (t)
			CT_D:    return "d";
			CT_I:    return "i";
			CT_O:    return "o";
			CT_U:    return "u";
			CT_LX:   return "x";
			CT_UX:   return "X";
			CT_LE:   return "e";
			CT_UE:   return "E";
			CT_F:    return "f";
			CT_LG:   return "g";
			CT_UG:   return "G";
			CT_C:    return "c";
			CT_S:    return "s";
			CT_P:    return "p";
			CT_N:    return "n";
			default: return CH_PERCENT;
		endcase
	endfunction

	// Decimal number: short, long enough to reach the digit limit, or right
	// at the saturation boundary.
	function automatic void add_number(input bit lead_nonzero, input int sel);
		string bound;
		int n;
		int i;
		if (sel == 2) begin
			if ($urandom_range(0, 1))
				bound = "4294967295";
			else
				bound = "4294967296";
			for (i = 0; i < bound.len(); i++)
				spec_text.push_back(bound[i]);
			return;
		end
		n = (sel == 1) ? $urandom_range(8, 22) : $urandom_range(1, 3);
		for (i = 0; i < n; i++) begin
			if (i == 0 && lead_nonzero)
				spec_text.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
			else
				spec_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		end
	endfunction

	// One random specifier attempt. Most are well formed; a share is tidied
	// so that the type accepts every part of it. The rest are stray bytes,
	// percent literals and specifiers cut off by a NUL or a random byte.
	task automatic send_random_spec(input bit huge);
		int kind;
		int n;
		int i;
		int f;
		int sel;
		int cut;
		conv_t t;
		bit tidy;
		logic [7:0] fc;
		spec_text.delete();
		kind = huge ? 99 : $urandom_range(0, 99);
		if (kind < 4) begin
			spec_text.push_back(CH_PERCENT);
			spec_text.push_back(CH_PERCENT);
		end else if (kind < 12) begin
			n = $urandom_range(1, 6);
			repeat (n)
				spec_text.push_back(8'($urandom_range(0, 255)));
		end else begin
			t = conv_t'($urandom_range(1, 15));
			tidy = huge || ($urandom_range(0, 99) < 60);
			spec_text.push_back(CH_PERCENT);

			// Flags; a huge run pushes the character count into saturation.
			if (huge)
				n = $urandom_range(256, 270);
			else if ($urandom_range(0, 19) == 0)
				n = $urandom_range(4, 8);
			else
				n = $urandom_range(0, 3);
			for (i = 0; i < n; i++) begin
				f = $urandom_range(0, 4);
				if (tidy && f == FB_ALT && !MASK_ALT[t])
					f = FB_LEFT;
				if (tidy && f == FB_ZERO && !MASK_ZPAD[t])
					f = FB_LEFT;
				case (f)
					FB_ALT:  fc = CH_HASH;
					FB_ZERO: fc = CH_ZERO;
					FB_LEFT: fc = CH_MINUS;
					FB_PLUS: fc = CH_PLUS;
					default: fc = CH_SPACE;
				endcase
				spec_text.push_back(fc);
			end

			// Width.
			sel = $urandom_range(0, 19);
			if (sel >= 8 && sel < 12)
				spec_text.push_back(CH_STAR);
			else if (sel >= 12 && sel < 18)
				add_number(1'b1, 0);
			else if (sel == 18)
				add_number(1'b1, 1);
			else if (sel == 19)
				add_number(1'b1, 2);

			// Precision, possibly empty.
			sel = $urandom_range(0, 19);
			if (sel >= 8 && !(tidy && !MASK_PREC[t])) begin
				spec_text.push_back(CH_DOT);
				if (sel >= 10 && sel < 13)
					spec_text.push_back(CH_STAR);
				else if (sel >= 13 && sel < 18)
					add_number(1'b0, 0);
				else if (sel == 18)
					add_number(1'b0, 1);
				else if (sel == 19)
					add_number(1'b0, 2);
			end

			// Length modifier.
			sel = $urandom_range(0, 5);
			if (tidy && (sel == 3 || sel == 4) && !MASK_HL[t])
				sel = 0;
			if (tidy && sel == 5 && !MASK_LDBL[t])
				sel = 0;
			if (sel == 3)
				spec_text.push_back(CH_LOW_H);
			else if (sel == 4)
				spec_text.push_back(CH_LOW_L);
			else if (sel == 5)
				spec_text.push_back(CH_UP_L);

			// Type letter, now and then a random byte instead.
			if (!huge && $urandom_range(0, 19) == 0)
				spec_text.push_back(8'($urandom_range(0, 255)));
			else
				spec_text.push_back(conv_letter(t));

			// Cut some specifiers short.
			if (kind < 22) begin
				cut = $urandom_range(1, spec_text.size() - 1);
				while (spec_text.size() > cut)
					void'(spec_text.pop_back());
				if ($urandom_range(0, 1))
					spec_text.push_back(CH_NUL);
				else
					spec_text.push_back(8'($urandom_range(0, 255)));
			end
		end
		specs_sent++;
		foreach (spec_text[k])
			send_char(spec_text[k]);
	endtask

	initial begin : stimulus
		int round;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-picked cases: bad start, NUL while idle, percent literal,
		// NUL inside a specifier, bad type, flag and length checks,
		// star width and an empty precision.
		send_text("x");
		send_char(CH_NUL);
		send_text("%%");
		send_text("%#x");
		send_text("%0");
		send_char(CH_NUL);
		send_text("%q");
		send_text("%Lf");
		send_text("%hs");
		send_text("%+*.d");
		wait_drained();

		// Three idling rounds: receiver-heavy, sender-heavy, none.
		for (round = 0; round < 3; round++) begin
			if (round == 0) begin
				send_idle_pct = 34;
				recv_idle_pct = 74;
			end else if (round == 1) begin
				send_idle_pct = 74;
				recv_idle_pct = 34;
				// Long output hold-off while bad-start items keep coming.
				hold_req = 1'b1;
				repeat (24)
					send_char(8'("A" + $urandom_range(0, 25)));
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				send_random_spec(1'b1);
			end
			while (chars_sent < (round + 1) * ITEMS / 3)
				send_random_spec(1'b0);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		$display("Run covered %0d characters in %0d specifier attempts under three idling rounds",
			chars_sent, specs_sent);
		$display("and one long output hold-off; %0d results checked, %0d valid specifiers.",
			results_seen, valid_seen);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/pcsp_pkg.sv
rtl/printf_conversion_spec_parser.sv
verif/spec_checker.sv
verif/testbench.sv
